FILE: sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Action and status codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

endpackage

`default_nettype wire

FILE: sv/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined add, subtract, multiply, divide
// One transaction accepted per cycle while op_stall is low.
// Depth is set by the restoring divider, one quotient bit per stage.
// Reset clears the stage valid bits only; the datapath is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit #(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          op_valid,
	output logic                         op_stall,
	input  wire  cau_pkg::action_t       action,
	input  wire  signed [WIDTH-1:0]      a_real,
	input  wire  signed [WIDTH-1:0]      a_imag,
	input  wire  signed [WIDTH-1:0]      b_real,
	input  wire  signed [WIDTH-1:0]      b_imag,
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic signed [WIDTH-1:0]      res_real,
	output logic signed [WIDTH-1:0]      res_imag,
	output cau_pkg::status_t             status
);

	import cau_pkg::*;

	localparam int PW  = 2 * WIDTH;
	localparam int SW  = 2 * WIDTH + 1;
	localparam int AW  = WIDTH + 1;
	localparam int DW  = 2 * WIDTH;
	localparam int MW  = 2 * WIDTH;
	localparam int NDW = 2 * WIDTH + FRAC_BITS + 1;
	localparam int TW  = (WIDTH + FRAC_BITS > 2 * WIDTH) ? WIDTH + FRAC_BITS : 2 * WIDTH;
	localparam int QW  = WIDTH + 1;

	localparam logic [WIDTH-1:0]     MAXV      = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0]     MINV      = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [QW-1:0]        Q_POS_LIM = {2'b00, {(WIDTH-1){1'b1}}};
	localparam logic [QW-1:0]        Q_NEG_LIM = {2'b01, {(WIDTH-1){1'b0}}};
	localparam logic signed [SW-1:0] MUL_HALF  = SW'((64'd1 << FRAC_BITS) >> 1);

	typedef struct packed {
		logic                    is_div;
		logic                    dz;
		logic signed [WIDTH-1:0] nd_re;
		logic signed [WIDTH-1:0] nd_im;
		logic                    nd_sat;
		logic [DW-1:0]           den;
		logic                    neg_re;
		logic                    neg_im;
		logic                    ovf_re;
		logic                    ovf_im;
		logic [DW-1:0]           rem_re;
		logic [DW-1:0]           rem_im;
		logic [QW-1:0]           lq_re;
		logic [QW-1:0]           lq_im;
	} dstage_t;

	// {flag, value}: clamp a wide signed value to the output range
	function automatic logic [WIDTH:0] sat_s(input logic signed [SW-1:0] v);
		logic [SW-WIDTH:0] top;
		begin
			top = v[SW-1:WIDTH-1];
			if ((&top) || (~|top))
				return {1'b0, v[WIDTH-1:0]};
			return {1'b1, v[SW-1] ? MINV : MAXV};
		end
	endfunction

	function automatic logic [WIDTH:0] sat_a(input logic signed [AW-1:0] v);
		logic [1:0] top;
		begin
			top = v[AW-1:WIDTH-1];
			if ((&top) || (~|top))
				return {1'b0, v[WIDTH-1:0]};
			return {1'b1, v[AW-1] ? MINV : MAXV};
		end
	endfunction

	// one restoring step: shift the next dividend bit in, shift the quotient bit in at the low end
	function automatic logic [DW+QW-1:0] lane_step(input logic [DW-1:0] rem,
			input logic [QW-1:0] lq, input logic [DW-1:0] den);
		logic [DW:0] t;
		logic        qb;
		begin
			t  = {rem, lq[QW-1]};
			qb = (t >= {1'b0, den});
			if (qb)
				t = t - {1'b0, den};
			return {t[DW-1:0], lq[QW-2:0], qb};
		end
	endfunction

	function automatic dstage_t div_step(input dstage_t d);
		dstage_t n;
		begin
			n = d;
			{n.rem_re, n.lq_re} = lane_step(d.rem_re, d.lq_re, d.den);
			{n.rem_im, n.lq_im} = lane_step(d.rem_im, d.lq_im, d.den);
			return n;
		end
	endfunction

	// apply sign to the quotient magnitude and clamp
	function automatic logic [WIDTH:0] lane_fin(input logic [QW-1:0] q,
			input logic neg, input logic ovf);
		logic [QW-1:0] qn;
		begin
			qn = -q;
			if (neg) begin
				if (ovf || (q > Q_NEG_LIM))
					return {1'b1, MINV};
				return {1'b0, qn[WIDTH-1:0]};
			end
			if (ovf || (q > Q_POS_LIM))
				return {1'b1, MAXV};
			return {1'b0, q[WIDTH-1:0]};
		end
	endfunction

	// ---------------- stall chain ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic vd_sd [QW];
	logic res_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_o;
	logic en_d [QW];

	assign en_o  = !res_valid_q || !res_stall;
	assign en_s4 = !v_s4 || en_d[0];
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign op_stall = !en_s1;

	// ---------------- stage 1: products, add/sub ----------------
	action_t                 act_s1;
	logic signed [PW-1:0]    prr_s1, pii_s1, pri_s1, pir_s1, pbr_s1, pbi_s1;
	logic signed [AW-1:0]    asr_s1, asi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			act_s1 <= action;
			prr_s1 <= a_real * b_real;
			pii_s1 <= a_imag * b_imag;
			pri_s1 <= a_real * b_imag;
			pir_s1 <= a_imag * b_real;
			pbr_s1 <= b_real * b_real;
			pbi_s1 <= b_imag * b_imag;
			if (action == ACT_SUB) begin
				asr_s1 <= AW'(a_real) - AW'(b_real);
				asi_s1 <= AW'(a_imag) - AW'(b_imag);
			end else begin
				asr_s1 <= AW'(a_real) + AW'(b_real);
				asi_s1 <= AW'(a_imag) + AW'(b_imag);
			end
		end
	end

	// ---------------- stage 2: cross sums, divisor ----------------
	action_t                 act_s2;
	logic signed [SW-1:0]    mre_s2, mim_s2, nre_s2, nim_s2;
	logic [DW-1:0]           den_s2;
	logic signed [AW-1:0]    asr_s2, asi_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			act_s2 <= act_s1;
			mre_s2 <= SW'(prr_s1) - SW'(pii_s1);
			mim_s2 <= SW'(pri_s1) + SW'(pir_s1);
			nre_s2 <= SW'(prr_s1) + SW'(pii_s1);
			nim_s2 <= SW'(pir_s1) - SW'(pri_s1);
			den_s2 <= $unsigned(pbr_s1) + $unsigned(pbi_s1);
			asr_s2 <= asr_s1;
			asi_s2 <= asi_s1;
		end
	end

	// ---------------- stage 3: round and clamp, build dividends ----------------
	logic signed [SW-1:0]    rnd_re, rnd_im, sh_re, sh_im;
	logic [WIDTH:0]          sr_re, sr_im;
	logic signed [WIDTH-1:0] nd_re_c, nd_im_c;
	logic                    nd_sat_c;
	logic                    neg_re_c, neg_im_c;
	logic [MW-1:0]           mag_re_c, mag_im_c;
	logic [NDW-1:0]          dvd_re_c, dvd_im_c;

	always_comb begin
		rnd_re = mre_s2 + MUL_HALF;
		rnd_im = mim_s2 + MUL_HALF;
		sh_re  = rnd_re >>> FRAC_BITS;
		sh_im  = rnd_im >>> FRAC_BITS;
		case (act_s2)
			ACT_ADD, ACT_SUB: begin
				sr_re = sat_a(asr_s2);
				sr_im = sat_a(asi_s2);
			end
			ACT_MUL: begin
				sr_re = sat_s(sh_re);
				sr_im = sat_s(sh_im);
			end
			default: begin
				sr_re = '0;
				sr_im = '0;
			end
		endcase
		nd_re_c  = $signed(sr_re[WIDTH-1:0]);
		nd_im_c  = $signed(sr_im[WIDTH-1:0]);
		nd_sat_c = sr_re[WIDTH] | sr_im[WIDTH];

		neg_re_c = nre_s2[SW-1];
		neg_im_c = nim_s2[SW-1];
		mag_re_c = neg_re_c ? MW'(-nre_s2) : MW'(nre_s2);
		mag_im_c = neg_im_c ? MW'(-nim_s2) : MW'(nim_s2);
		dvd_re_c = (NDW'(mag_re_c) << FRAC_BITS) + NDW'(den_s2 >> 1);
		dvd_im_c = (NDW'(mag_im_c) << FRAC_BITS) + NDW'(den_s2 >> 1);
	end

	logic                    is_div_s3, dz_s3, nd_sat_s3, neg_re_s3, neg_im_s3;
	logic signed [WIDTH-1:0] nd_re_s3, nd_im_s3;
	logic [DW-1:0]           den_s3;
	logic [NDW-1:0]          dvd_re_s3, dvd_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			is_div_s3 <= (act_s2 == ACT_DIV);
			dz_s3     <= (den_s2 == '0);
			nd_re_s3  <= nd_re_c;
			nd_im_s3  <= nd_im_c;
			nd_sat_s3 <= nd_sat_c;
			den_s3    <= den_s2;
			neg_re_s3 <= neg_re_c;
			neg_im_s3 <= neg_im_c;
			dvd_re_s3 <= dvd_re_c;
			dvd_im_s3 <= dvd_im_c;
		end
	end

	// ---------------- stage 4: overflow check, divider setup ----------------
	// Quotient needs only WIDTH+1 bits; anything larger saturates anyway.
	dstage_t d4_c, ds_s4;

	always_comb begin
		d4_c.is_div = is_div_s3;
		d4_c.dz     = dz_s3;
		d4_c.nd_re  = nd_re_s3;
		d4_c.nd_im  = nd_im_s3;
		d4_c.nd_sat = nd_sat_s3;
		d4_c.den    = den_s3;
		d4_c.neg_re = neg_re_s3;
		d4_c.neg_im = neg_im_s3;
		d4_c.ovf_re = TW'(dvd_re_s3 >> (WIDTH + 1)) >= TW'(den_s3);
		d4_c.ovf_im = TW'(dvd_im_s3 >> (WIDTH + 1)) >= TW'(den_s3);
		d4_c.rem_re = DW'(dvd_re_s3 >> (WIDTH + 1));
		d4_c.rem_im = DW'(dvd_im_s3 >> (WIDTH + 1));
		d4_c.lq_re  = dvd_re_s3[WIDTH:0];
		d4_c.lq_im  = dvd_im_s3[WIDTH:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ds_s4 <= d4_c;
		end
	end

	// ---------------- divider stages: one quotient bit each ----------------
	dstage_t ds_sd [QW];

	for (genvar k = 0; k < QW; k++) begin : g_div
		dstage_t prv;
		logic    prv_v;

		if (k == 0) begin : g_first
			assign prv   = ds_s4;
			assign prv_v = v_s4;
		end else begin : g_next
			assign prv   = ds_sd[k-1];
			assign prv_v = vd_sd[k-1];
		end

		if (k == QW - 1) begin : g_en_last
			assign en_d[k] = !vd_sd[k] || en_o;
		end else begin : g_en_mid
			assign en_d[k] = !vd_sd[k] || en_d[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_sd[k] <= 1'b0;
			end else if (en_d[k]) begin
				vd_sd[k] <= prv_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en_d[k]) begin
				ds_sd[k] <= div_step(prv);
			end
		end
	end

	// ---------------- output register ----------------
	dstage_t                 dl;
	logic [WIDTH:0]          fr, fi;
	logic signed [WIDTH-1:0] out_re_c, out_im_c;
	status_t                 out_st_c;

	always_comb begin
		dl = ds_sd[QW-1];
		fr = lane_fin(dl.lq_re, dl.neg_re, dl.ovf_re);
		fi = lane_fin(dl.lq_im, dl.neg_im, dl.ovf_im);
		if (!dl.is_div) begin
			out_re_c = dl.nd_re;
			out_im_c = dl.nd_im;
			out_st_c = dl.nd_sat ? ST_SAT : ST_OK;
		end else if (dl.dz) begin
			out_re_c = '0;
			out_im_c = '0;
			out_st_c = ST_DIV0;
		end else begin
			out_re_c = $signed(fr[WIDTH-1:0]);
			out_im_c = $signed(fi[WIDTH-1:0]);
			out_st_c = (fr[WIDTH] | fi[WIDTH]) ? ST_SAT : ST_OK;
		end
	end

	logic signed [WIDTH-1:0] res_real_q, res_imag_q;
	status_t                 status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en_o) begin
			res_valid_q <= vd_sd[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			res_real_q <= out_re_c;
			res_imag_q <= out_im_c;
			status_q   <= out_st_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res_real  = res_real_q;
	assign res_imag  = res_imag_q;
	assign status    = status_q;

endmodule

`default_nettype wire

FILE: bench/cau_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cau_checker
// Watches both channels of the complex arithmetic unit. Computes the expected
// sum, difference, product or quotient of every operand transaction and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------

module cau_checker #(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 8
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     op_valid,
	input  wire                     op_stall,
	input  cau_pkg::action_t        action,
	input  wire signed [WIDTH-1:0]  a_real,
	input  wire signed [WIDTH-1:0]  a_imag,
	input  wire signed [WIDTH-1:0]  b_real,
	input  wire signed [WIDTH-1:0]  b_imag,
	input  wire                     res_valid,
	input  wire                     res_stall,
	input  wire signed [WIDTH-1:0]  res_real,
	input  wire signed [WIDTH-1:0]  res_imag,
	input  cau_pkg::status_t        status,
	output int                      errors,
	output int                      pending
);

	import cau_pkg::*;

	typedef struct {
		logic signed [WIDTH-1:0] re;
		logic signed [WIDTH-1:0] im;
		status_t                 st;
	} cplx_result_t;

	cplx_result_t predicted_results[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	// round half toward plus infinity
	function automatic longint round_product(input longint s);
		if (FRAC_BITS > 0)
			s = s + (longint'(1) <<< (FRAC_BITS - 1));
		return s >>> FRAC_BITS;
	endfunction

	// round on magnitudes, half away from zero
	function automatic longint round_quotient(input longint num, input longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = ((mag <<< FRAC_BITS) + (den >>> 1)) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [WIDTH-1:0] clamp_part(input longint v, inout bit clipped);
		longint hi_lim;
		longint lo_lim;
		hi_lim = (longint'(1) <<< (WIDTH - 1)) - 1;
		lo_lim = -hi_lim - 1;
		if (v > hi_lim) begin
			clipped = 1'b1;
			return hi_lim[WIDTH-1:0];
		end
		if (v < lo_lim) begin
			clipped = 1'b1;
			return lo_lim[WIDTH-1:0];
		end
		return v[WIDTH-1:0];
	endfunction

	function automatic cplx_result_t compute_complex_op(
		input action_t                 act,
		input logic signed [WIDTH-1:0] ar,
		input logic signed [WIDTH-1:0] ai,
		input logic signed [WIDTH-1:0] br,
		input logic signed [WIDTH-1:0] bi
	);
		cplx_result_t r;
		longint xr, xi, yr, yi, re_w, im_w, den;
		bit clipped;
		xr = longint'(ar);
		xi = longint'(ai);
		yr = longint'(br);
		yi = longint'(bi);
		re_w = 0;
		im_w = 0;
		clipped = 1'b0;
		case (act)
			ACT_ADD: begin
				re_w = xr + yr;
				im_w = xi + yi;
			end
			ACT_SUB: begin
				re_w = xr - yr;
				im_w = xi - yi;
			end
			ACT_MUL: begin
				re_w = round_product(xr * yr - xi * yi);
				im_w = round_product(xr * yi + xi * yr);
			end
			default: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DIV0;
					return r;
				end
				re_w = round_quotient(xr * yr + xi * yi, den);
				im_w = round_quotient(xi * yr - xr * yi, den);
			end
		endcase
		r.re = clamp_part(re_w, clipped);
		r.im = clamp_part(im_w, clipped);
		r.st = clipped ? ST_SAT : ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		// keep the log short when the design is badly broken
		if (errors <= 100)
			$display("[%0t] cau_checker: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		cplx_result_t want;
		if (arst_n) begin
			if (op_valid && !op_stall)
				predicted_results.push_back(compute_complex_op(action, a_real, a_imag,
					b_real, b_imag));
			if (res_valid && !res_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d %0d %s",
						res_real, res_imag, status.name()));
				end else begin
					want = predicted_results.pop_front();
					if (res_real !== want.re)
						report_mismatch($sformatf("res_real %0d, expected %0d",
							res_real, want.re));
					if (res_imag !== want.im)
						report_mismatch($sformatf("res_imag %0d, expected %0d",
							res_imag, want.im));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, expected %s",
							status, want.st.name()));
				end
			end
			pending <= predicted_results.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives operand transactions into the complex arithmetic unit: a directed
// set of edge cases, then random operands under three idling patterns.
// Prediction and comparison happen in the checker beside the design.
// ----------------------------------------------------------------------------

module tb_top;

	import cau_pkg::*;

	localparam int WIDTH     = 16;
	localparam int FRAC_BITS = 8;
	localparam int RANDOM_PER_PHASE = 634;
	localparam int DRAIN_CYCLES     = 40;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    op_valid  = 1'b0;
	logic                    res_stall = 1'b0;
	action_t                 action    = ACT_ADD;
	logic signed [WIDTH-1:0] a_real    = '0;
	logic signed [WIDTH-1:0] a_imag    = '0;
	logic signed [WIDTH-1:0] b_real    = '0;
	logic signed [WIDTH-1:0] b_imag    = '0;

	wire                     op_stall;
	wire                     res_valid;
	wire signed [WIDTH-1:0]  res_real;
	wire signed [WIDTH-1:0]  res_imag;
	status_t                 status;

	int errors;
	int pending;
	int send_idle_pct = 6;
	int recv_idle_pct = 77;

	complex_arithmetic_unit #(
		.WIDTH     (WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.action    (action),
		.a_real    (a_real),
		.a_imag    (a_imag),
		.b_real    (b_real),
		.b_imag    (b_imag),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_real  (res_real),
		.res_imag  (res_imag),
		.status    (status)
	);

	cau_checker #(
		.WIDTH     (WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.action    (action),
		.a_real    (a_real),
		.a_imag    (a_imag),
		.b_real    (b_real),
		.b_imag    (b_imag),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_real  (res_real),
		.res_imag  (res_imag),
		.status    (status),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// random idle cycles, then present the transaction and hold it until taken
	task automatic send_operands(
		input action_t act,
		input int      ar,
		input int      ai,
		input int      br,
		input int      bi
	);
		while ($urandom_range(99) < send_idle_pct) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		action   <= act;
		a_real   <= WIDTH'(ar);
		a_imag   <= WIDTH'(ai);
		b_real   <= WIDTH'(br);
		b_imag   <= WIDTH'(bi);
		do @(posedge clk); while (op_stall);
	endtask

	function automatic int pick_operand();
		int v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = int'($urandom_range(65535)) - 32768;
			4, 5, 6:    v = int'($urandom_range(1023)) - 512;
			7: begin
				case ($urandom_range(6))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					3: v = -1;
					4: v = 1;
					5: v = 256;
					default: v = -256;
				endcase
			end
			default:    v = int'($urandom_range(8191)) - 4096;
		endcase
		return v;
	endfunction

	task automatic send_random_op();
		action_t act;
		int br, bi;
		act = action_t'($urandom_range(3));
		br  = pick_operand();
		bi  = pick_operand();
		if (act == ACT_DIV) begin
			case ($urandom_range(15))
				0: begin
					br = 0;
					bi = 0;
				end
				1: br = 0;
				2: bi = 0;
				default: ;
			endcase
		end
		send_operands(act, pick_operand(), pick_operand(), br, bi);
	endtask

	task automatic run_directed();
		send_operands(ACT_ADD, 32767, 32767, 32767, 32767);
		send_operands(ACT_ADD, -32768, -32768, -32768, -32768);
		send_operands(ACT_ADD, 256, -512, 768, 100);
		send_operands(ACT_SUB, -32768, 32767, 32767, -32768);
		send_operands(ACT_SUB, 1000, -1000, -1000, 1000);
		send_operands(ACT_SUB, 0, 0, -32768, -32768);
		send_operands(ACT_MUL, 256, 0, 256, 0);
		// exact half of an LSB rounds up for both signs
		send_operands(ACT_MUL, 1, 0, 128, 0);
		send_operands(ACT_MUL, -1, 0, 128, 0);
		send_operands(ACT_MUL, -32768, -32768, -32768, -32768);
		send_operands(ACT_MUL, 32767, 32767, 32767, -32768);
		send_operands(ACT_MUL, 384, 64, -256, 512);
		// zero divisor
		send_operands(ACT_DIV, 256, 256, 0, 0);
		send_operands(ACT_DIV, 0, 0, 0, 0);
		send_operands(ACT_DIV, -32768, 32767, 0, 0);
		send_operands(ACT_DIV, 256, 0, 256, 0);
		send_operands(ACT_DIV, 256, 0, 0, 256);
		send_operands(ACT_DIV, -32768, 0, 1, 0);
		send_operands(ACT_DIV, 32767, -32768, -32768, -32768);
		// quotient ties round away from zero
		send_operands(ACT_DIV, 1, 0, 512, 0);
		send_operands(ACT_DIV, -1, 0, 512, 0);
		send_operands(ACT_DIV, 100, -200, 3, -7);
		send_operands(ACT_DIV, 0, 1, 0, -1);
	endtask

	initial begin
		int waited;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		repeat (RANDOM_PER_PHASE) send_random_op();

		send_idle_pct = 77;
		recv_idle_pct = 6;
		repeat (RANDOM_PER_PHASE) send_random_op();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RANDOM_PER_PHASE) send_random_op();
		op_valid <= 1'b0;

		waited = 0;
		@(posedge clk);
		while (pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#1000000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: files.f
sv/cau_pkg.sv
sv/complex_arithmetic_unit.sv
bench/cau_checker.sv
bench/tb_top.sv
